[hw/rtl/ntsc_pkg.sv]
// Shared types, constants and the step table builder for the tick scaler.
package ntsc_pkg;

    localparam int DATA_WIDTH      = 48;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MAX_REQUEST_DEF = 1024;
    localparam int REQ_IN_W        = 10;
    localparam int COUNT_W         = 12;
    localparam int COUNT_MAX       = 4095;
    localparam int THRESH_W        = 16;
    localparam int THRESH_RESET    = 1;
    localparam int EXP_MIN         = -12;
    localparam int EXP_COUNT       = 32;
    localparam int SERIES_LEN      = 3 * EXP_COUNT;
    localparam int SERIES_W        = $clog2(SERIES_LEN);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] range_start;
        logic signed [DATA_WIDTH-1:0] range_stop;
        logic [REQ_IN_W-1:0]          requested_count;
    } ntsc_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] scaled_start;
        logic signed [DATA_WIDTH-1:0] scaled_stop;
        logic [COUNT_W-1:0]           interval_count;
        logic                         span_is_zero;
        logic                         step_underflow;
    } ntsc_out_t;

    typedef logic [63:0] step_tab_t [SERIES_LEN];

    // Builds the 1-2-5 series in LSBs; a zero entry marks a step that does not exist.
    function automatic step_tab_t build_steps(input int frac);
        step_tab_t tab;
        logic [63:0] v;
        logic [63:0] p;
        logic [63:0] y;
        logic        ovf;
        int          e;
        int          m;
        for (int j = 0; j < SERIES_LEN; j++) begin
            e = EXP_MIN + j / 3;
            m = (j % 3 == 0) ? 1 : ((j % 3 == 1) ? 2 : 5);
            v = 64'(m) << frac;
            ovf = 1'b0;
            if (e < 0) begin
                p = 64'd1;
                for (int k = 0; k < -e; k++) begin
                    p = p * 64'd10;
                end
                if (v < p) begin
                    tab[j] = 64'd0;
                end else begin
                    // Round half up: floor((2v + p) / (2p)) by repeated division by ten.
                    y = (2 * v + p) >> 1;
                    for (int k = 0; k < -e; k++) begin
                        y = y / 10;
                    end
                    tab[j] = y;
                end
            end else begin
                for (int k = 0; k < e; k++) begin
                    if (v > 64'hFFFF_FFFF_FFFF_FFFF / 10) begin
                        ovf = 1'b1;
                    end
                    v = v * 64'd10;
                end
                tab[j] = ovf ? 64'd0 : v;
            end
        end
        return tab;
    endfunction

endpackage

[hw/rtl/nice_axis_tick_scaler_core.sv]
// Axis tick scaler: picks a 1-2-5 step and snaps a range to whole ticks.
//
// Input words arrive on s_valid/s_ready and carry both range ends and the
// wanted interval count. Result words leave on m_valid/m_ready. The threshold
// for a zero-length span is written through cfg_valid/cfg_data, which is
// always ready; write it only while the block is idle.
// One word is worked on at a time: s_ready is high only in the idle state.
// After the prepare and span states, a coarse step search walks the step
// table down to the first step no larger than the span; then each step tried
// runs two divisions, since one bit-serial divider computes both the tick
// offset and the tick count. A zero-length span skips the search and divider.
// A finished result sits in the output register; the next word can be taken
// while it waits. If a second result is ready before the first is taken,
// the sequencer waits until the output register frees.
// Reset clears the sequencer and the output valid and sets the threshold to 1.
module nice_axis_tick_scaler_core
    import ntsc_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ntsc_in_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ntsc_out_t           m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [THRESH_W-1:0] cfg_data
);

    localparam int DW    = DATA_WIDTH;
    localparam int REQ_W = $clog2(MAX_REQUEST + 1);
    localparam int CW    = (DW > REQ_W) ? DW : REQ_W;
    localparam int DCW   = $clog2(DW);
    localparam step_tab_t STEPS = build_steps(FRAC_BITS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_SPAN   = 4'd2;
    localparam logic [3:0] S_SEARCH = 4'd3;
    localparam logic [3:0] S_DIV1   = 4'd4;
    localparam logic [3:0] S_OFF    = 4'd5;
    localparam logic [3:0] S_LD2    = 4'd6;
    localparam logic [3:0] S_DIV2   = 4'd7;
    localparam logic [3:0] S_EVAL   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0]          state_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic signed [DW-1:0] lo_reg, hi_reg;
    logic [DW-1:0]       span_reg, labs_reg, step_reg, off_reg;
    logic                lo_neg_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [SERIES_W-1:0] idx_reg;
    logic [DW-1:0]       div_n_reg, div_r_reg;
    logic [DCW-1:0]      div_cnt_reg;
    logic [DW-1:0]       p_off_reg, p_rem_reg, sel_off_reg, sel_rem_reg;
    logic [CW-1:0]       p_cnt_reg, sel_cnt_reg;
    logic                walked_reg, zero_reg, under_reg;
    logic                m_valid_reg;
    ntsc_out_t           m_data_reg;

    logic [DW:0]         trial;
    logic                trial_ge;
    logic [DW-1:0]       trial_sub;
    logic [63:0]         tab_cur, tab_next;
    logic [SERIES_W-1:0] idx_next;
    logic [CW-1:0]       cnt_cur, req_ext;
    logic [REQ_W-1:0]    req_clamp;
    logic [COUNT_W-1:0]  cnt_sat;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Shared restoring divider step: one quotient bit per cycle.
    assign trial     = {div_r_reg, div_n_reg[DW-1]};
    assign trial_ge  = (trial >= {1'b0, step_reg});
    assign trial_sub = DW'(trial - {1'b0, step_reg});

    assign tab_cur  = STEPS[idx_reg];
    assign idx_next = (idx_reg == '0) ? '0 : idx_reg - 1'b1;
    assign tab_next = STEPS[idx_next];
    assign cnt_cur  = CW'(div_n_reg);
    assign req_ext  = CW'(req_reg);
    assign req_clamp = (32'(s_data.requested_count) > MAX_REQUEST) ? REQ_W'(MAX_REQUEST) :
                       (s_data.requested_count == '0) ? REQ_W'(1) :
                       REQ_W'(s_data.requested_count);
    assign cnt_sat  = (sel_cnt_reg > CW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                     : COUNT_W'(sel_cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_W'(THRESH_RESET);
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // In the finishing state the output register is handled below.
            if (m_valid_reg && m_ready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_data.range_start > s_data.range_stop) begin
                            lo_reg <= s_data.range_stop;
                            hi_reg <= s_data.range_start;
                        end else begin
                            lo_reg <= s_data.range_start;
                            hi_reg <= s_data.range_stop;
                        end
                        req_reg    <= req_clamp;
                        walked_reg <= 1'b0;
                        zero_reg   <= 1'b0;
                        under_reg  <= 1'b0;
                        state_reg  <= S_PREP;
                    end
                end
                S_PREP: begin
                    span_reg   <= DW'(hi_reg - lo_reg);
                    labs_reg   <= lo_reg[DW-1] ? DW'(-lo_reg) : DW'(lo_reg);
                    lo_neg_reg <= lo_reg[DW-1];
                    idx_reg    <= SERIES_W'(SERIES_LEN - 1);
                    state_reg  <= S_SPAN;
                end
                S_SPAN: begin
                    sel_off_reg <= '0;
                    sel_rem_reg <= '0;
                    sel_cnt_reg <= req_ext;
                    if (span_reg <= DW'(thresh_reg)) begin
                        zero_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (tab_cur != 64'd0 && tab_cur <= 64'(span_reg)) begin
                        step_reg    <= DW'(tab_cur);
                        div_n_reg   <= labs_reg;
                        div_r_reg   <= '0;
                        div_cnt_reg <= DCW'(DW - 1);
                        state_reg   <= S_DIV1;
                    end else if (idx_reg == '0) begin
                        under_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end else begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                S_DIV1, S_DIV2: begin
                    div_r_reg <= trial_ge ? trial_sub : trial[DW-1:0];
                    div_n_reg <= {div_n_reg[DW-2:0], trial_ge};
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0) begin
                        state_reg <= (state_reg == S_DIV1) ? S_OFF : S_EVAL;
                    end
                end
                S_OFF: begin
                    // Distance from the low end up to the first multiple of the step.
                    if (lo_neg_reg || div_r_reg == '0) begin
                        off_reg <= div_r_reg;
                    end else begin
                        off_reg <= step_reg - div_r_reg;
                    end
                    state_reg <= S_LD2;
                end
                S_LD2: begin
                    div_n_reg   <= span_reg - off_reg;
                    div_r_reg   <= '0;
                    div_cnt_reg <= DCW'(DW - 1);
                    state_reg   <= S_DIV2;
                end
                S_EVAL: begin
                    if (cnt_cur >= req_ext) begin
                        if (walked_reg && (req_ext - p_cnt_reg < cnt_cur - req_ext)) begin
                            sel_off_reg <= p_off_reg;
                            sel_rem_reg <= p_rem_reg;
                            sel_cnt_reg <= p_cnt_reg;
                        end else begin
                            sel_off_reg <= off_reg;
                            sel_rem_reg <= div_r_reg;
                            sel_cnt_reg <= cnt_cur;
                        end
                        state_reg <= S_FIN;
                    end else begin
                        p_off_reg  <= off_reg;
                        p_rem_reg  <= div_r_reg;
                        p_cnt_reg  <= cnt_cur;
                        walked_reg <= 1'b1;
                        if (idx_reg == '0 || tab_next == 64'd0) begin
                            sel_off_reg <= off_reg;
                            sel_rem_reg <= div_r_reg;
                            sel_cnt_reg <= cnt_cur;
                            under_reg   <= 1'b1;
                            state_reg   <= S_FIN;
                        end else begin
                            idx_reg     <= idx_next;
                            step_reg    <= DW'(tab_next);
                            div_n_reg   <= labs_reg;
                            div_r_reg   <= '0;
                            div_cnt_reg <= DCW'(DW - 1);
                            state_reg   <= S_DIV1;
                        end
                    end
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        // The last tick is the high end less what is left over.
                        m_data_reg.scaled_start   <= lo_reg + $signed(sel_off_reg);
                        m_data_reg.scaled_stop    <= hi_reg - $signed(sel_rem_reg);
                        m_data_reg.interval_count <= cnt_sat;
                        m_data_reg.span_is_zero   <= zero_reg;
                        m_data_reg.step_underflow <= under_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/ntsc_checker.sv]
// Port-level checks for the tick scaler and the bind that attaches them.
module ntsc_checker
    import ntsc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input ntsc_out_t m_data
);

    // A stalled result word must stay put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // The block works on one word at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is still in work");

    // A zero-length span never also reports a step underflow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.span_is_zero && m_data.step_underflow))
        else $error("both special flags set");

    // A regular result never puts the first tick past the last one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.span_is_zero && !m_data.step_underflow
        |-> m_data.scaled_start <= m_data.scaled_stop)
        else $error("first tick above last tick");

endmodule

bind nice_axis_tick_scaler_core ntsc_checker u_ntsc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
